// File: hdl/ttl_pkg.sv
// Shared types, constants and helper functions for the template tag lexer.
package ttl_pkg;

  // Trailing-whitespace buffer sizing
  localparam int SPACE_DEPTH = 8;
  localparam int CNT_W       = $clog2(SPACE_DEPTH + 1);
  localparam int IDX_W       = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;

  // Delimiter characters
  localparam logic [7:0] CHR_LBRACE = 8'h7B;
  localparam logic [7:0] CHR_RBRACE = 8'h7D;
  localparam logic [7:0] CHR_PCT    = 8'h25;
  localparam logic [7:0] CHR_HASH   = 8'h23;

  // Token kinds
  localparam logic [1:0] KIND_TEXT  = 2'd0;
  localparam logic [1:0] KIND_VAR   = 2'd1;
  localparam logic [1:0] KIND_BLOCK = 2'd2;

  // Lexer mode; odd codes mean a held opening brace or closing character
  typedef enum logic [2:0] {
    M_TEXT          = 3'd0,
    M_TEXT_BRACE    = 3'd1,
    M_VAR           = 3'd2,
    M_VAR_CLOSE     = 3'd3,
    M_BLOCK         = 3'd4,
    M_BLOCK_CLOSE   = 3'd5,
    M_COMMENT       = 3'd6,
    M_COMMENT_CLOSE = 3'd7
  } mode_t;

  // Datapath operations
  typedef enum logic [2:0] {
    OP_NONE      = 3'd0,
    OP_TEXT_CHAR = 3'd1,
    OP_TEXT_END  = 3'd2,
    OP_TAG_CHAR  = 3'd3,
    OP_END_TAG   = 3'd4,
    OP_FIN       = 3'd5
  } op_t;

  // Operand character select
  typedef enum logic [1:0] {
    SEL_IN     = 2'd0,
    SEL_LBRACE = 2'd1,
    SEL_CLOSER = 2'd2
  } chsel_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_M1   = 3'd1,
    S_M2   = 3'd2,
    S_E1   = 3'd3,
    S_E2   = 3'd4,
    S_FIN  = 3'd5
  } ctl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic   load;
    op_t    op;
    chsel_t sel;
    logic   mode_wr;
    mode_t  mode_val;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    mode_t mode;
    logic  c_lbrace;
    logic  c_pct;
    logic  c_hash;
    logic  c_rbrace;
    logic  c_closer;
    logic  eot;
    logic  op_done;
  } stat_t;

  // One result
  typedef struct packed {
    logic [1:0] kind;
    logic       has;
    logic [7:0] ch;
    logic       tend;
    logic       ovf;
    logic       done;
  } res_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic [7:0] closer_of(input mode_t base);
    logic [7:0] r;
    case (base)
      M_VAR:   r = CHR_RBRACE;
      M_BLOCK: r = CHR_PCT;
      default: r = CHR_HASH;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/ttl_ctrl.sv
// Sequencer that walks each input byte through its operation slots.
module ttl_ctrl import ttl_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  stat_t st,
  output cmd_t  cmd
);

  ctl_state_t state_r, state_nxt;
  ctl_state_t after;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    cmd       = '0;
    cmd.op    = OP_NONE;
    cmd.sel   = SEL_IN;
    cmd.mode_val = M_TEXT;
    in_tready = 1'b0;
    after     = state_r;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
        after     = S_M1;
      end
      // first slot, driven by the mode at the start of the byte
      S_M1: begin
        after = S_E1;
        if (st.mode == M_TEXT) begin
          if (st.c_lbrace) begin
            cmd.mode_wr  = 1'b1;
            cmd.mode_val = M_TEXT_BRACE;
          end else begin
            cmd.op = OP_TEXT_CHAR;
          end
        end else if (st.mode == M_TEXT_BRACE) begin
          if (st.c_lbrace || st.c_pct || st.c_hash) begin
            cmd.op       = OP_TEXT_END;
            cmd.mode_wr  = 1'b1;
            cmd.mode_val = st.c_lbrace ? M_VAR : (st.c_pct ? M_BLOCK : M_COMMENT);
          end else begin
            cmd.op  = OP_TEXT_CHAR;
            cmd.sel = SEL_LBRACE;
            after   = S_M2;
          end
        end else if (!st.mode[0]) begin
          if (st.c_closer) begin
            cmd.mode_wr  = 1'b1;
            cmd.mode_val = mode_t'({st.mode[2:1], 1'b1});
          end else begin
            cmd.op = OP_TAG_CHAR;
          end
        end else begin
          if (st.c_rbrace) begin
            cmd.op       = OP_END_TAG;
            cmd.mode_wr  = 1'b1;
            cmd.mode_val = M_TEXT;
          end else begin
            cmd.op  = OP_TAG_CHAR;
            cmd.sel = SEL_CLOSER;
            after   = st.c_closer ? S_E1 : S_M2;
          end
        end
      end
      // second slot: the byte itself after a released brace or closer
      S_M2: begin
        after       = S_E1;
        cmd.mode_wr = 1'b1;
        if (st.mode == M_TEXT_BRACE) begin
          cmd.op       = OP_TEXT_CHAR;
          cmd.mode_val = M_TEXT;
        end else begin
          cmd.op       = OP_TAG_CHAR;
          cmd.mode_val = mode_t'({st.mode[2:1], 1'b0});
        end
      end
      // end of text: close whatever is open
      S_E1: begin
        after = S_FIN;
        if (st.eot) begin
          if (st.mode == M_TEXT_BRACE) begin
            cmd.op       = OP_TEXT_CHAR;
            cmd.sel      = SEL_LBRACE;
            cmd.mode_wr  = 1'b1;
            cmd.mode_val = M_TEXT;
            after        = S_E2;
          end else if (st.mode == M_TEXT) begin
            cmd.op = OP_TEXT_END;
          end else if (!st.mode[0]) begin
            cmd.op       = OP_END_TAG;
            cmd.mode_wr  = 1'b1;
            cmd.mode_val = M_TEXT;
          end else begin
            cmd.op  = OP_TAG_CHAR;
            cmd.sel = SEL_CLOSER;
            after   = S_E2;
          end
        end
      end
      S_E2: begin
        after = S_FIN;
        if (st.mode == M_TEXT) begin
          cmd.op = OP_TEXT_END;
        end else begin
          cmd.op       = OP_END_TAG;
          cmd.mode_wr  = 1'b1;
          cmd.mode_val = M_TEXT;
        end
      end
      S_FIN: begin
        cmd.op = OP_FIN;
        after  = S_IDLE;
      end
      default: begin
        after = S_IDLE;
      end
    endcase
    if (state_r == S_IDLE) begin
      if (in_tvalid) begin
        state_nxt = after;
      end
    end else if (st.op_done) begin
      state_nxt = after;
    end
  end

endmodule

// File: hdl/ttl_datapath.sv
// Lexer state, whitespace buffer, result staging and output register.
module ttl_datapath import ttl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_tdata,   // [7:0] char_byte
  input  logic        in_tlast,   // end_of_text
  input  cmd_t        cmd,
  output stat_t       st,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_char, [8] text_done, [15:9] zero
  output logic [3:0]  out_tuser,  // [1:0] token_kind, [2] has_char, [3] space_overflow
  output logic        out_tlast   // token_end
);

  mode_t            mode_r, mode_nxt;
  logic             nonempty_r, nonempty_nxt;
  logic             started_r, started_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic [7:0]       pend_r [SPACE_DEPTH];
  logic [7:0]       ch_r;
  logic             eot_r;
  logic             stg_v_r, stg_v_nxt;
  res_t             stg_r, stg_nxt;
  logic             out_v_r, out_v_nxt;
  res_t             out_r, out_nxt;

  logic             out_free, emit_ok, emit, done, sp, is_cmt, reset_lex;
  logic             pend_we;
  logic [7:0]       opch;
  logic [1:0]       kind;
  mode_t            base;
  res_t             eres;

  assign base     = mode_t'({mode_r[2:1], 1'b0});
  assign kind     = (base == M_VAR) ? KIND_VAR : KIND_BLOCK;
  assign is_cmt   = (base == M_COMMENT);
  assign out_free = !out_v_r || out_tready;
  assign emit_ok  = !stg_v_r || out_free;

  // Operand character
  always_comb begin
    case (cmd.sel)
      SEL_LBRACE: opch = CHR_LBRACE;
      SEL_CLOSER: opch = closer_of(base);
      default:    opch = ch_r;
    endcase
  end
  assign sp = is_space(opch);

  // Status toward the controller
  assign st.mode     = mode_r;
  assign st.c_lbrace = (ch_r == CHR_LBRACE);
  assign st.c_pct    = (ch_r == CHR_PCT);
  assign st.c_hash   = (ch_r == CHR_HASH);
  assign st.c_rbrace = (ch_r == CHR_RBRACE);
  assign st.c_closer = (ch_r == closer_of(base));
  assign st.eot      = eot_r;
  assign st.op_done  = done;

  // Operation execution
  always_comb begin
    nonempty_nxt = nonempty_r;
    started_nxt  = started_r;
    cnt_nxt      = cnt_r;
    ptr_nxt      = ptr_r;
    stg_v_nxt    = stg_v_r;
    stg_nxt      = stg_r;
    out_v_nxt    = out_v_r && !out_tready;
    out_nxt      = out_r;
    emit         = 1'b0;
    eres         = '0;
    done         = 1'b0;
    pend_we      = 1'b0;
    reset_lex    = 1'b0;
    case (cmd.op)
      OP_TEXT_CHAR: begin
        if (emit_ok) begin
          emit         = 1'b1;
          eres.kind    = KIND_TEXT;
          eres.has     = 1'b1;
          eres.ch      = opch;
          nonempty_nxt = 1'b1;
          done         = 1'b1;
        end
      end
      OP_TEXT_END: begin
        if (!nonempty_r || emit_ok) begin
          emit         = nonempty_r;
          eres.kind    = KIND_TEXT;
          eres.tend    = 1'b1;
          nonempty_nxt = 1'b0;
          started_nxt  = 1'b0;
          cnt_nxt      = '0;
          ptr_nxt      = '0;
          done         = 1'b1;
        end
      end
      OP_TAG_CHAR: begin
        if (is_cmt) begin
          done = 1'b1;
        end else if (sp) begin
          if (!started_r) begin
            done = 1'b1;
          end else if (cnt_r < CNT_W'(SPACE_DEPTH)) begin
            pend_we = 1'b1;
            cnt_nxt = cnt_r + CNT_W'(1);
            done    = 1'b1;
          end else if (emit_ok) begin
            // buffer full: drop the space, flag it
            emit      = 1'b1;
            eres.kind = kind;
            eres.ovf  = 1'b1;
            done      = 1'b1;
          end
        end else if (ptr_r < cnt_r) begin
          // flush held whitespace one byte per cycle while results can move on (emit_ok)
          if (emit_ok) begin
            emit      = 1'b1;
            eres.kind = kind;
            eres.has  = 1'b1;
            eres.ch   = pend_r[ptr_r[IDX_W-1:0]];
            ptr_nxt   = ptr_r + CNT_W'(1);
          end
        end else if (emit_ok) begin
          emit        = 1'b1;
          eres.kind   = kind;
          eres.has    = 1'b1;
          eres.ch     = opch;
          started_nxt = 1'b1;
          cnt_nxt     = '0;
          ptr_nxt     = '0;
          done        = 1'b1;
        end
      end
      OP_END_TAG: begin
        if (is_cmt || emit_ok) begin
          emit        = !is_cmt;
          eres.kind   = kind;
          eres.tend   = 1'b1;
          started_nxt = 1'b0;
          cnt_nxt     = '0;
          ptr_nxt     = '0;
          done        = 1'b1;
        end
      end
      OP_FIN: begin
        // release the staged result, marking the last one of the text
        if (stg_v_r) begin
          if (out_free) begin
            out_v_nxt    = 1'b1;
            out_nxt      = stg_r;
            out_nxt.done = eot_r;
            stg_v_nxt    = 1'b0;
            done         = 1'b1;
          end
        end else if (eot_r) begin
          if (out_free) begin
            out_v_nxt    = 1'b1;
            out_nxt      = '0;
            out_nxt.done = 1'b1;
            done         = 1'b1;
          end
        end else begin
          done = 1'b1;
        end
        reset_lex = done && eot_r;
      end
      default: begin
        done = 1'b1;
      end
    endcase

    // staging: a new result pushes the previous one out
    if (emit) begin
      if (stg_v_r) begin
        out_v_nxt    = 1'b1;
        out_nxt      = stg_r;
        out_nxt.done = 1'b0;
      end
      stg_v_nxt = 1'b1;
      stg_nxt   = eres;
    end

    mode_nxt = (done && cmd.mode_wr) ? cmd.mode_val : mode_r;
    if (reset_lex) begin
      mode_nxt     = M_TEXT;
      nonempty_nxt = 1'b0;
      started_nxt  = 1'b0;
      cnt_nxt      = '0;
      ptr_nxt      = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= M_TEXT;
      nonempty_r <= 1'b0;
      started_r  <= 1'b0;
      cnt_r      <= '0;
      ptr_r      <= '0;
      stg_v_r    <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      mode_r     <= mode_nxt;
      nonempty_r <= nonempty_nxt;
      started_r  <= started_nxt;
      cnt_r      <= cnt_nxt;
      ptr_r      <= ptr_nxt;
      stg_v_r    <= stg_v_nxt;
      out_v_r    <= out_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    stg_r <= stg_nxt;
    out_r <= out_nxt;
    if (cmd.load) begin
      ch_r  <= in_tdata;
      eot_r <= in_tlast;
    end
    if (pend_we) begin
      pend_r[cnt_r[IDX_W-1:0]] <= opch;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'd0, out_r.done, out_r.ch};
  assign out_tuser  = {out_r.ovf, out_r.has, out_r.kind};
  assign out_tlast  = out_r.tend;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(SPACE_DEPTH))
    else $error("whitespace count beyond buffer depth");

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= cnt_r)
    else $error("flush pointer past held whitespace");

  a_fin_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_FIN) && done && eot_r |=> (mode_r == M_TEXT) && (cnt_r == '0) && !stg_v_r)
    else $error("lexer state not cleared after end of text");

  a_out_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !(out_r.has && (out_r.tend || out_r.ovf)))
    else $error("character result carries a marker flag");

endmodule

// File: hdl/template_tag_lexer_core.sv
// Top level of the template tag lexer: sequencer plus datapath.
// Each byte passes through accept, byte slot, end-of-text slot and release, plus any extra
//   slot and one flush step per held whitespace byte.
// Throughput: one byte at a time; the next byte is taken once the release slot ends.
// Results pass through a staging register and an output register, so the final
//   result of a step is known before it is shown.
// Reset (rst_n low, synchronous): text mode, whitespace buffer empty, no results held.
module template_tag_lexer_core import ttl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_byte
  input  logic        in_tlast,   // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_char, [8] text_done, [15:9] zero
  output logic [3:0]  out_tuser,  // [1:0] token_kind, [2] has_char, [3] space_overflow
  output logic        out_tlast   // token_end
);

  cmd_t  cmd;
  stat_t st;

  ttl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  ttl_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cmd        (cmd),
    .st         (st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
